>>> design/ffha_pkg.sv
`timescale 1ns / 1ps
package ffha_pkg;

   localparam int ARENA_BYTES  = 4096;
   localparam int HEADER_BYTES = 16;
   localparam int MAX_BLOCKS   = 256;

   localparam int IDX_W  = $clog2(MAX_BLOCKS);
   localparam int CNT_W  = IDX_W + 1;
   localparam int OFF_W  = $clog2(ARENA_BYTES);
   localparam int CALC_W = ((OFF_W > 12) ? OFF_W : 12) + 2;

   localparam int ENTRY_W = 2 * OFF_W + 1;

   typedef enum logic [1:0] {
      ST_DONE    = 2'd0,
      ST_NO_FIT  = 2'd1,
      ST_BAD_OFF = 2'd2
   } status_type;

   typedef enum logic {
      ACT_ALLOC = 1'b0,
      ACT_FREE  = 1'b1
   } action_type;

   typedef struct packed {
      logic [OFF_W-1:0] start;
      logic [OFF_W-1:0] size;
      logic             used;
   } entry_type;

endpackage

>>> design/ffha_if.sv
`timescale 1ns / 1ps
interface ffha_req_if;
   logic        valid;
   logic        ready;
   logic        action;
   logic [11:0] request_size;
   logic [11:0] data_offset;
   modport source (output valid, action, request_size, data_offset, input ready);
   modport sink (input valid, action, request_size, data_offset, output ready);
endinterface

interface ffha_rsp_if;
   logic        valid;
   logic        ready;
   logic [1:0]  status;
   logic [11:0] granted_offset;
   logic [11:0] free_bytes;
   modport source (output valid, status, granted_offset, free_bytes, input ready);
   modport sink (input valid, status, granted_offset, free_bytes, output ready);
endinterface

>>> design/ffha_ram.sv
`timescale 1ns / 1ps
module ffha_ram #(
   parameter int WIDTH = 8,
   parameter int DEPTH = 16
) (
   input  logic                     clock,
   input  logic                     wr_en,
   input  logic [$clog2(DEPTH)-1:0] wr_addr,
   input  logic [WIDTH-1:0]         wr_data,
   input  logic [$clog2(DEPTH)-1:0] rd_addr,
   output logic [WIDTH-1:0]         rd_data
);
   logic [WIDTH-1:0] mem [DEPTH];

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem[wr_addr] <= wr_data;
      end
      rd_data <= mem[rd_addr];
   end
endmodule

>>> design/first_fit_heap_allocator.sv
`timescale 1ns / 1ps
// channel  | dir | handshake           | payload
// req_ch   | in  | valid/ready         | action, request_size, data_offset
// rsp_ch   | out | valid/ready         | status, granted_offset, free_bytes
//
// One request at a time. The block table sits in one 1R1W RAM, one entry per cycle.
// Allocate: scan to the hit, a split shifts count-1-i entries up, then S_FIXA and S_FIXB write.
// Free: scan to the hit, S_FNEXT takes the next entry, merges shift the tail down.
// After reset S_INIT0 and S_INIT1 write the initial entries.
// A response waits in its register; a new request is taken while it is not yet taken.
module first_fit_heap_allocator
   import ffha_pkg::*;
(
   input logic      clock,
   input logic      reset,
   ffha_req_if.sink   req_ch,
   ffha_rsp_if.source rsp_ch
);

   typedef enum logic [3:0] {
      S_INIT0, S_INIT1, S_IDLE, S_SCAN, S_FNEXT, S_MOVE, S_FIXA, S_FIXB, S_DONE
   } state_type;

   state_type            state_ff;
   logic                 act_ff;
   logic [11:0]          req_size_ff;
   logic [11:0]          offset_ff;
   logic [CNT_W-1:0]     idx_ff;
   logic [CNT_W-1:0]     count_ff;
   logic [OFF_W-1:0]     bytes_ff;
   entry_type            prev_ff;
   entry_type            cur_ff;
   logic [IDX_W-1:0]     mv_next_ff;
   logic [CNT_W-1:0]     mv_left_ff;
   logic [IDX_W-1:0]     mv_src_ff;
   logic                 mv_pend_ff;
   logic                 mv_up_ff;
   logic [1:0]           mv_sh_ff;
   logic [IDX_W-1:0]     fixa_addr_ff;
   entry_type            fixa_ff;
   logic [IDX_W-1:0]     fixb_addr_ff;
   entry_type            fixb_ff;
   logic                 fixb_en_ff;
   status_type           status_ff;
   logic [11:0]          granted_ff;
   logic                 rsp_valid_ff;
   logic [1:0]           rsp_status_ff;
   logic [11:0]          rsp_granted_ff;
   logic [11:0]          rsp_free_ff;

   logic                 ram_we;
   logic [IDX_W-1:0]     ram_waddr;
   entry_type            ram_wdata;
   logic [IDX_W-1:0]     ram_raddr;
   entry_type            rd;
   logic [ENTRY_W-1:0]   rd_bits;

   assign rd = entry_type'(rd_bits);

   ffha_ram #(.WIDTH(ENTRY_W), .DEPTH(MAX_BLOCKS)) u_table (
      .clock   (clock),
      .wr_en   (ram_we),
      .wr_addr (ram_waddr),
      .wr_data (ram_wdata),
      .rd_addr (ram_raddr),
      .rd_data (rd_bits)
   );

   // scan checks, all in a widened domain
   logic [CALC_W-1:0] rd_size_x, rd_start_x, req_x, hdr_x;
   logic              alloc_hit, can_split, free_hit, scan_end;
   logic [CNT_W-1:0]  idx_next;

   assign rd_size_x  = CALC_W'(rd.size);
   assign rd_start_x = CALC_W'(rd.start);
   assign req_x      = CALC_W'(req_size_ff);
   assign hdr_x      = CALC_W'(HEADER_BYTES);
   assign idx_next   = idx_ff + 1'b1;
   assign can_split  = (rd_size_x > req_x + hdr_x) && (count_ff < CNT_W'(MAX_BLOCKS));
   assign alloc_hit  = !rd.used && ((rd_size_x == req_x) || can_split);
   assign free_hit   = rd.used && (rd_start_x + hdr_x == CALC_W'(offset_ff));
   assign scan_end   = (act_ff == ACT_ALLOC) ? (idx_ff == count_ff) : (idx_next == count_ff);

   // merge terms for a free
   logic              nf, pf;
   logic [CALC_W-1:0] merged_x, prev_merged_x, bytes_gain_x;
   assign nf            = !rd.used;
   assign pf            = (idx_ff != '0) && !prev_ff.used;
   assign merged_x      = CALC_W'(cur_ff.size) + (nf ? hdr_x + rd_size_x : '0);
   assign prev_merged_x = CALC_W'(prev_ff.size) + hdr_x + merged_x;
   assign bytes_gain_x  = CALC_W'(cur_ff.size) + (nf ? hdr_x : '0) + (pf ? hdr_x : '0);

   logic [IDX_W-1:0] mv_dst;
   assign mv_dst = mv_up_ff ? mv_src_ff + 1'b1 : mv_src_ff - IDX_W'(mv_sh_ff);

   always_comb begin
      ram_we    = 1'b0;
      ram_waddr = '0;
      ram_wdata = '0;
      ram_raddr = '0;
      case (state_ff)
         S_INIT0: begin
            ram_we    = 1'b1;
            ram_waddr = '0;
            ram_wdata = '{start: '0, size: OFF_W'(ARENA_BYTES - 2 * HEADER_BYTES), used: 1'b0};
         end
         S_INIT1: begin
            ram_we    = 1'b1;
            ram_waddr = IDX_W'(1);
            ram_wdata = '{start: OFF_W'(ARENA_BYTES - HEADER_BYTES), size: '0, used: 1'b1};
         end
         S_SCAN:  ram_raddr = idx_next[IDX_W-1:0];
         S_MOVE: begin
            ram_raddr = mv_next_ff;
            ram_we    = mv_pend_ff;
            ram_waddr = mv_dst;
            ram_wdata = rd;
         end
         S_FIXA: begin
            ram_we    = 1'b1;
            ram_waddr = fixa_addr_ff;
            ram_wdata = fixa_ff;
         end
         S_FIXB: begin
            ram_we    = fixb_en_ff;
            ram_waddr = fixb_addr_ff;
            ram_wdata = fixb_ff;
         end
         default: ram_raddr = '0;
      endcase
   end

   assign req_ch.ready          = (state_ff == S_IDLE);
   assign rsp_ch.valid          = rsp_valid_ff;
   assign rsp_ch.status         = rsp_status_ff;
   assign rsp_ch.granted_offset = rsp_granted_ff;
   assign rsp_ch.free_bytes     = rsp_free_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= S_INIT0;
         count_ff     <= CNT_W'(2);
         bytes_ff     <= OFF_W'(ARENA_BYTES - 2 * HEADER_BYTES);
         rsp_valid_ff <= 1'b0;
         mv_pend_ff   <= 1'b0;
      end else begin
         // in S_DONE the response register is reloaded instead
         if (rsp_valid_ff && rsp_ch.ready && state_ff != S_DONE) begin
            rsp_valid_ff <= 1'b0;
         end
         case (state_ff)
            S_INIT0: state_ff <= S_INIT1;
            S_INIT1: state_ff <= S_IDLE;
            S_IDLE: begin
               if (req_ch.valid) begin
                  act_ff      <= req_ch.action;
                  req_size_ff <= req_ch.request_size;
                  offset_ff   <= req_ch.data_offset;
                  idx_ff      <= '0;
                  granted_ff  <= '0;
                  state_ff    <= S_SCAN;
               end
            end
            S_SCAN: begin
               if (scan_end) begin
                  status_ff <= (act_ff == ACT_ALLOC) ? ST_NO_FIT : ST_BAD_OFF;
                  state_ff  <= S_DONE;
               end else if (act_ff == ACT_ALLOC && alloc_hit) begin
                  status_ff    <= ST_DONE;
                  granted_ff   <= 12'((rd_start_x + hdr_x));
                  fixa_addr_ff <= idx_ff[IDX_W-1:0];
                  fixa_ff      <= '{start: rd.start, size: OFF_W'(req_size_ff), used: 1'b1};
                  mv_up_ff     <= 1'b1;
                  mv_sh_ff     <= 2'd1;
                  mv_pend_ff   <= 1'b0;
                  if (rd_size_x == req_x) begin
                     bytes_ff   <= bytes_ff - rd.size;
                     fixb_en_ff <= 1'b0;
                     mv_left_ff <= '0;
                  end else begin
                     bytes_ff     <= OFF_W'(CALC_W'(bytes_ff) - hdr_x - req_x);
                     fixb_en_ff   <= 1'b1;
                     fixb_addr_ff <= idx_next[IDX_W-1:0];
                     fixb_ff      <= '{start: OFF_W'(rd_start_x + hdr_x + req_x),
                                      size: OFF_W'(rd_size_x - hdr_x - req_x), used: 1'b0};
                     mv_next_ff   <= IDX_W'(count_ff - 1'b1);
                     mv_left_ff   <= count_ff - idx_next;
                     count_ff     <= count_ff + 1'b1;
                  end
                  state_ff <= S_MOVE;
               end else if (act_ff == ACT_FREE && free_hit) begin
                  // read of the next entry is already in flight
                  status_ff <= ST_DONE;
                  cur_ff    <= rd;
                  state_ff  <= S_FNEXT;
               end else begin
                  prev_ff <= rd;
                  idx_ff  <= idx_next;
               end
            end
            S_FNEXT: begin
               bytes_ff   <= OFF_W'(CALC_W'(bytes_ff) + bytes_gain_x);
               fixb_en_ff <= 1'b0;
               mv_up_ff   <= 1'b0;
               mv_pend_ff <= 1'b0;
               mv_sh_ff   <= {1'b0, nf} + {1'b0, pf};
               if (pf) begin
                  fixa_addr_ff <= IDX_W'(idx_ff - 1'b1);
                  fixa_ff      <= '{start: prev_ff.start, size: OFF_W'(prev_merged_x),
                                    used: 1'b0};
               end else begin
                  fixa_addr_ff <= idx_ff[IDX_W-1:0];
                  fixa_ff      <= '{start: cur_ff.start, size: OFF_W'(merged_x), used: 1'b0};
               end
               mv_next_ff <= IDX_W'(idx_next + CNT_W'(nf));
               if (nf || pf) begin
                  mv_left_ff <= count_ff - idx_next - CNT_W'(nf);
               end else begin
                  mv_left_ff <= '0;
               end
               count_ff <= count_ff - CNT_W'(nf) - CNT_W'(pf);
               state_ff <= S_MOVE;
            end
            S_MOVE: begin
               if (mv_left_ff != '0) begin
                  mv_next_ff <= mv_up_ff ? mv_next_ff - 1'b1 : mv_next_ff + 1'b1;
                  mv_left_ff <= mv_left_ff - 1'b1;
                  mv_src_ff  <= mv_next_ff;
                  mv_pend_ff <= 1'b1;
               end else begin
                  mv_pend_ff <= 1'b0;
                  if (!mv_pend_ff) begin
                     state_ff <= S_FIXA;
                  end
               end
            end
            S_FIXA: state_ff <= fixb_en_ff ? S_FIXB : S_DONE;
            S_FIXB: state_ff <= S_DONE;
            S_DONE: begin
               if (!rsp_valid_ff || rsp_ch.ready) begin
                  rsp_valid_ff   <= 1'b1;
                  rsp_status_ff  <= status_ff;
                  rsp_granted_ff <= granted_ff;
                  rsp_free_ff    <= 12'(CALC_W'(bytes_ff));
                  state_ff       <= S_IDLE;
               end
            end
            default: state_ff <= S_IDLE;
         endcase
      end
   end

   a_count_range: assert property (@(posedge clock) disable iff (reset)
      (count_ff >= CNT_W'(2)) && (count_ff <= CNT_W'(MAX_BLOCKS)))
      else $error("block count out of range");

   a_bytes_bound: assert property (@(posedge clock) disable iff (reset)
      CALC_W'(bytes_ff) <= CALC_W'(ARENA_BYTES - 2 * HEADER_BYTES))
      else $error("free byte count above arena size");

   a_idle_no_write: assert property (@(posedge clock) disable iff (reset)
      (state_ff == S_IDLE) |-> !ram_we)
      else $error("table write while idle");

   a_accept_scan: assert property (@(posedge clock) disable iff (reset)
      (req_ch.valid && req_ch.ready) |=> (state_ff == S_SCAN) && (idx_ff == '0))
      else $error("request not followed by scan from entry zero");

endmodule
